// ----- hw/rtl/sls_pkg.sv -----
`default_nettype none

package sls_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned CTX_W          = 3;
    localparam int unsigned FIFO_DEPTH_DEF = 4;

    localparam logic [CTX_W-1:0] CTX_PLAIN   = 3'd0;
    localparam logic [CTX_W-1:0] CTX_PUNCT   = 3'd1;
    localparam logic [CTX_W-1:0] CTX_PUNCT_S = 3'd2;
    localparam logic [CTX_W-1:0] CTX_CLOSE   = 3'd3;
    localparam logic [CTX_W-1:0] CTX_CLOSE_S = 3'd4;
    localparam logic [CTX_W-1:0] CTX_SPACE   = 3'd5;
    localparam logic [CTX_W-1:0] CTX_OPEN    = 3'd6;

    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;

    localparam logic [1:0] CNT_NONE  = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // one input's worth of output, bytes in emit order b0, b1, b2
    typedef struct packed {
        logic [1:0]        cnt;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b0;
    } cmd_t;

    function automatic logic is_stop(input logic [BYTE_W-1:0] c);
        return (c == CH_DOT) || (c == CH_QUEST) || (c == CH_COLON) || (c == CH_SEMI);
    endfunction

    function automatic logic is_upper(input logic [BYTE_W-1:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_digit_lower(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sls_front.sv -----
`default_nettype none

module sls_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [sls_pkg::BYTE_W-1:0] s_tdata,
    input  wire logic                       q_full,
    output logic                            q_push,
    output sls_pkg::cmd_t                   q_cmd
);

    logic [sls_pkg::CTX_W-1:0]  ctx_reg;
    logic [sls_pkg::CTX_W-1:0]  ctx_next;
    logic [sls_pkg::BYTE_W-1:0] c;
    logic                       accept;
    logic                       stop;
    logic                       up;
    logic                       dl;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign c        = s_tdata;
    assign stop     = sls_pkg::is_stop(c);
    assign up       = sls_pkg::is_upper(c);
    assign dl       = sls_pkg::is_digit_lower(c);

    always_comb
    begin
        ctx_next  = ctx_reg;
        q_cmd.cnt = sls_pkg::CNT_NONE;
        q_cmd.b0  = c;
        q_cmd.b1  = c;
        q_cmd.b2  = c;
        case (ctx_reg)
            sls_pkg::CTX_PUNCT:
            begin
                if (stop)
                begin
                    q_cmd.cnt = sls_pkg::CNT_ONE;
                end
                else if (c == sls_pkg::CH_SPACE)
                begin
                    ctx_next = sls_pkg::CTX_PUNCT_S;
                end
                else if (c == sls_pkg::CH_CLOSE)
                begin
                    q_cmd.cnt = sls_pkg::CNT_ONE;
                    ctx_next  = sls_pkg::CTX_CLOSE;
                end
                else
                begin
                    q_cmd.cnt = sls_pkg::CNT_ONE;
                    ctx_next  = sls_pkg::CTX_PLAIN;
                end
            end
            sls_pkg::CTX_PUNCT_S:
            begin
                if (stop)
                begin
                    q_cmd.cnt = sls_pkg::CNT_TWO;
                    q_cmd.b0  = sls_pkg::CH_SPACE;
                    ctx_next  = sls_pkg::CTX_PUNCT;
                end
                else if (c == sls_pkg::CH_SPACE)
                begin
                    ctx_next = ctx_reg;
                end
                else if (c == sls_pkg::CH_OPEN)
                begin
                    ctx_next = sls_pkg::CTX_OPEN;
                end
                else if (c == sls_pkg::CH_CLOSE)
                begin
                    q_cmd.cnt = sls_pkg::CNT_ONE;
                    ctx_next  = sls_pkg::CTX_CLOSE;
                end
                else
                begin
                    q_cmd.cnt = sls_pkg::CNT_TWO;
                    q_cmd.b0  = dl ? sls_pkg::CH_SPACE : sls_pkg::CH_NL;
                    ctx_next  = sls_pkg::CTX_PLAIN;
                end
            end
            sls_pkg::CTX_CLOSE:
            begin
                if (stop)
                begin
                    q_cmd.cnt = sls_pkg::CNT_ONE;
                    ctx_next  = sls_pkg::CTX_PUNCT;
                end
                else if (c == sls_pkg::CH_SPACE)
                begin
                    ctx_next = sls_pkg::CTX_CLOSE_S;
                end
                else if (c == sls_pkg::CH_CLOSE)
                begin
                    q_cmd.cnt = sls_pkg::CNT_ONE;
                end
                else
                begin
                    q_cmd.cnt = sls_pkg::CNT_ONE;
                    ctx_next  = sls_pkg::CTX_PLAIN;
                end
            end
            sls_pkg::CTX_CLOSE_S:
            begin
                if (stop)
                begin
                    q_cmd.cnt = sls_pkg::CNT_TWO;
                    q_cmd.b0  = sls_pkg::CH_SPACE;
                    ctx_next  = sls_pkg::CTX_PUNCT;
                end
                else if (c == sls_pkg::CH_SPACE)
                begin
                    ctx_next = ctx_reg;
                end
                else if (c == sls_pkg::CH_OPEN)
                begin
                    ctx_next = sls_pkg::CTX_OPEN;
                end
                else if (c == sls_pkg::CH_CLOSE)
                begin
                    q_cmd.cnt = sls_pkg::CNT_TWO;
                    q_cmd.b0  = sls_pkg::CH_SPACE;
                    ctx_next  = sls_pkg::CTX_CLOSE;
                end
                else
                begin
                    q_cmd.cnt = sls_pkg::CNT_TWO;
                    q_cmd.b0  = up ? sls_pkg::CH_NL : sls_pkg::CH_SPACE;
                    ctx_next  = sls_pkg::CTX_PLAIN;
                end
            end
            sls_pkg::CTX_SPACE:
            begin
                if (stop)
                begin
                    q_cmd.cnt = sls_pkg::CNT_TWO;
                    q_cmd.b0  = sls_pkg::CH_SPACE;
                    ctx_next  = sls_pkg::CTX_PUNCT;
                end
                else if (c == sls_pkg::CH_SPACE)
                begin
                    ctx_next = ctx_reg;
                end
                else if (c == sls_pkg::CH_OPEN)
                begin
                    ctx_next = sls_pkg::CTX_OPEN;
                end
                else if (c == sls_pkg::CH_CLOSE)
                begin
                    q_cmd.cnt = sls_pkg::CNT_TWO;
                    q_cmd.b0  = sls_pkg::CH_SPACE;
                    ctx_next  = sls_pkg::CTX_CLOSE;
                end
                else
                begin
                    q_cmd.cnt = sls_pkg::CNT_TWO;
                    q_cmd.b0  = sls_pkg::CH_SPACE;
                    ctx_next  = sls_pkg::CTX_PLAIN;
                end
            end
            sls_pkg::CTX_OPEN:
            begin
                q_cmd.b0 = sls_pkg::CH_SPACE;
                q_cmd.b1 = sls_pkg::CH_OPEN;
                if (stop)
                begin
                    q_cmd.cnt = sls_pkg::CNT_THREE;
                    ctx_next  = sls_pkg::CTX_PUNCT;
                end
                else if (c == sls_pkg::CH_SPACE)
                begin
                    q_cmd.cnt = sls_pkg::CNT_TWO;
                    ctx_next  = sls_pkg::CTX_SPACE;
                end
                else if ((c == sls_pkg::CH_OPEN) || (c == sls_pkg::CH_CLOSE))
                begin
                    q_cmd.cnt = sls_pkg::CNT_THREE;
                    ctx_next  = sls_pkg::CTX_PLAIN;
                end
                else
                begin
                    q_cmd.cnt = sls_pkg::CNT_THREE;
                    q_cmd.b0  = up ? sls_pkg::CH_NL : sls_pkg::CH_SPACE;
                    ctx_next  = sls_pkg::CTX_PLAIN;
                end
            end
            default:
            begin
                if (stop)
                begin
                    q_cmd.cnt = sls_pkg::CNT_ONE;
                    ctx_next  = sls_pkg::CTX_PUNCT;
                end
                else if (c == sls_pkg::CH_SPACE)
                begin
                    ctx_next = sls_pkg::CTX_SPACE;
                end
                else if (c == sls_pkg::CH_CLOSE)
                begin
                    q_cmd.cnt = sls_pkg::CNT_ONE;
                    ctx_next  = sls_pkg::CTX_CLOSE;
                end
                else
                begin
                    q_cmd.cnt = sls_pkg::CNT_ONE;
                    ctx_next  = sls_pkg::CTX_PLAIN;
                end
            end
        endcase
    end

    assign q_push = accept && (q_cmd.cnt != sls_pkg::CNT_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= sls_pkg::CTX_PLAIN;
        end
        else if (accept)
        begin
            ctx_reg <= ctx_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sls_fifo.sv -----
`default_nettype none

module sls_fifo
#(
    parameter int unsigned DEPTH = sls_pkg::FIFO_DEPTH_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sls_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output sls_pkg::cmd_t      head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

    sls_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sls_back.sv -----
`default_nettype none

module sls_back
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       head_valid,
    input  wire sls_pkg::cmd_t              head_cmd,
    output logic                            pop,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [sls_pkg::BYTE_W-1:0]      m_tdata,
    output logic                            m_tlast
);

    sls_pkg::cmd_t              cmd_reg;
    sls_pkg::cmd_t              cmd_next;
    logic [1:0]                 idx_reg;
    logic [1:0]                 idx_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic [sls_pkg::BYTE_W-1:0] data_reg;
    logic [sls_pkg::BYTE_W-1:0] data_next;
    logic                       last_reg;
    logic                       last_next;

    sls_pkg::cmd_t              src;
    logic [1:0]                 idx;
    logic [sls_pkg::BYTE_W-1:0] cur_byte;
    logic                       cur_last;
    logic                       load;
    logic                       have;

    assign load = !valid_reg || m_tready;
    assign have = busy_reg || head_valid;
    assign pop  = load && !busy_reg && head_valid;
    assign src  = busy_reg ? cmd_reg : head_cmd;
    assign idx  = busy_reg ? idx_reg : 2'd0;

    always_comb
    begin
        case (idx)
            2'd0:    cur_byte = src.b0;
            2'd1:    cur_byte = src.b1;
            default: cur_byte = src.b2;
        endcase
    end

    assign cur_last = ((idx + 2'd1) == src.cnt);

    always_comb
    begin
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = have;
            if (have)
            begin
                data_next = cur_byte;
                last_next = cur_last;
                busy_next = !cur_last;
                idx_next  = idx + 2'd1;
                if (pop)
                begin
                    cmd_next = head_cmd;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sentence_line_splitter.sv -----
// sentence_line_splitter: text filter that starts each sentence on a new line.
// Input stream s_*: one text byte per word. Output stream m_*: one byte per
// word, m_tlast high on the final byte caused by an input byte.
// Each input byte yields zero to three output bytes; space runs collapse to
// one space, or to a newline before a word that opens a new sentence.
// An accepted input's command is registered in the queue, its first byte then
// in the output register. Throughput: one input word per cycle while each
// input yields at most one byte and m_tready is high; the output register
// emits one byte per cycle, so an input that yields several bytes holds the
// serializer for all of them. The command queue between the classifier and
// the serializer (FIFO_DEPTH entries) absorbs such bursts; s_tready drops only
// when it is full. Back-pressure: with m_tready low the output word holds, the
// queue fills, then s_tready falls. Nothing is lost.
// Reset (rst_n low, async): context returns to plain, the queue empties and
// the output goes invalid. Held spaces or '(' at end of stream are dropped.
`default_nettype none

module sentence_line_splitter
#(
    parameter int unsigned FIFO_DEPTH = sls_pkg::FIFO_DEPTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [sls_pkg::BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [sls_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
    output logic                            m_tlast
);

    logic          q_full;
    logic          q_push;
    sls_pkg::cmd_t q_cmd;
    logic          q_pop;
    logic          q_valid;
    sls_pkg::cmd_t q_head;

    sls_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    sls_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    sls_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_cmd   (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/sls_checker.sv -----
`default_nettype none

module sls_checker
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic [sls_pkg::BYTE_W-1:0] s_tdata,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [sls_pkg::BYTE_W-1:0] m_tdata,
    input wire logic                       m_tlast
);

    // input word holds while stalled
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("s_tvalid/s_tdata changed while stalled");

    // output word holds while stalled
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("m_tdata/m_tlast changed while stalled");

    // a space is always a held separator, never the closing byte
    a_space_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == sls_pkg::CH_SPACE) |-> !m_tlast)
        else $error("space emitted as last byte");

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind sentence_line_splitter sls_checker u_sls_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
